// File: src/iord_pkg.sv
package iord_pkg;

    // decoded address space: 128 KB mirror split into 8 KB regions
    localparam int MIRROR_BITS = 17;
    localparam int REGION_BITS = 13;
    localparam int REGION_SEL_BITS = MIRROR_BITS - REGION_BITS;

    localparam logic [MIRROR_BITS-1:0] TIMER1_BASE  = 17'h00000;
    localparam logic [MIRROR_BITS-1:0] TIMER2_BASE  = 17'h02000;
    localparam logic [MIRROR_BITS-1:0] SERIAL_BASE  = 17'h04000;
    localparam logic [MIRROR_BITS-1:0] PDMA_BASE    = 17'h06000;
    localparam logic [MIRROR_BITS-1:0] DISKREG_BASE = 17'h10000;
    localparam logic [MIRROR_BITS-1:0] BLIND_BASE   = 17'h12000;
    localparam logic [MIRROR_BITS-1:0] SOUND_BASE   = 17'h14000;
    localparam logic [MIRROR_BITS-1:0] FLOPPY_BASE  = 17'h16000;

    // region select codes taken from the top address bits
    localparam logic [REGION_SEL_BITS-1:0] RGN_TIMER1  = TIMER1_BASE[MIRROR_BITS-1:REGION_BITS];
    localparam logic [REGION_SEL_BITS-1:0] RGN_TIMER2  = TIMER2_BASE[MIRROR_BITS-1:REGION_BITS];
    localparam logic [REGION_SEL_BITS-1:0] RGN_SERIAL  = SERIAL_BASE[MIRROR_BITS-1:REGION_BITS];
    localparam logic [REGION_SEL_BITS-1:0] RGN_PDMA    = PDMA_BASE[MIRROR_BITS-1:REGION_BITS];
    localparam logic [REGION_SEL_BITS-1:0] RGN_DISKREG = DISKREG_BASE[MIRROR_BITS-1:REGION_BITS];
    localparam logic [REGION_SEL_BITS-1:0] RGN_BLIND   = BLIND_BASE[MIRROR_BITS-1:REGION_BITS];
    localparam logic [REGION_SEL_BITS-1:0] RGN_SOUND   = SOUND_BASE[MIRROR_BITS-1:REGION_BITS];
    localparam logic [REGION_SEL_BITS-1:0] RGN_FLOPPY  = FLOPPY_BASE[MIRROR_BITS-1:REGION_BITS];

    localparam logic [REGION_BITS-1:0] PDMA_RD_REG = 13'h000;
    localparam logic [REGION_BITS-1:0] PDMA_WR_REG = 13'h201;

    localparam int PEN_BITS = 5;
    localparam logic [PEN_BITS-1:0] TIMER_PENALTY     = 5'd16;
    localparam logic [PEN_BITS-1:0] OTHER_PENALTY     = 5'd2;
    localparam logic [PEN_BITS-1:0] LONG_PDMA_PENALTY = 5'd8;
    localparam logic [PEN_BITS-1:0] NO_PENALTY        = 5'd0;

    // access size codes
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;
    localparam logic [1:0] SIZE_LONG = 2'd2;

    typedef enum logic [2:0] {
        DEV_TIMER1 = 3'd0,
        DEV_TIMER2 = 3'd1,
        DEV_SERIAL = 3'd2,
        DEV_DISK   = 3'd3,
        DEV_SOUND  = 3'd4,
        DEV_FLOPPY = 3'd5,
        DEV_NONE   = 3'd6
    } t_dev;

    typedef struct packed {
        t_dev                  dev;
        logic [REGION_BITS-1:0] roff;
        logic [PEN_BITS-1:0]    pen;
    } t_byte_dec;

    // pseudo-dma data regions
    function automatic logic is_pdma(input logic [MIRROR_BITS-1:0] off);
        logic [REGION_SEL_BITS-1:0] rgn;
        rgn = off[MIRROR_BITS-1:REGION_BITS];
        return (rgn == RGN_PDMA) || (rgn == RGN_BLIND);
    endfunction

endpackage

// File: src/io_region_access_decoder.sv
// Splits each bus access into byte beats, most significant byte first, and
// decodes every byte to a device select, register offset and wait penalty.
// One byte beat leaves per cycle through the result register unless i_ready
// stalls it; the rate is set by the byte sequencer, which an access holds
// for one beat per byte (byte, word, longword). An accepted access is held
// in the access register and each beat is then loaded into the result
// register; the next access is taken in the cycle its predecessor's last
// beat is loaded, so back-to-back accesses leave no gap on the result side.
module io_region_access_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // access channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [1:0]  i_access_size,
    input  logic [31:0] i_bus_address,
    input  logic [31:0] i_write_data,
    // byte beat channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_device_select,
    output logic [12:0] o_register_offset,
    output logic        o_is_write,
    output logic [7:0]  o_byte_value,
    output logic [1:0]  o_byte_lane,
    output logic [4:0]  o_penalty_cycles,
    output logic        o_last_access
);

    // access register
    logic                             r_act_valid, n_act_valid;
    logic [1:0]                       r_lane, n_lane;
    logic                             r_wr;
    logic [1:0]                       r_size;
    logic [iord_pkg::MIRROR_BITS-1:0] r_addr;
    logic [31:0]                      r_data;

    // result register
    logic                             r_out_valid, n_out_valid;
    iord_pkg::t_byte_dec              r_dec;
    logic                             r_out_wr;
    logic [7:0]                       r_out_byte;
    logic [1:0]                       r_out_lane;
    logic                             r_out_last;

    logic                             out_free;
    logic                             emit;
    logic                             take;
    logic [1:0]                       last_lane;
    logic                             is_last;
    logic [1:0]                       shift_sel;
    logic [iord_pkg::MIRROR_BITS-1:0] byte_off;
    logic                             long_pdma;
    iord_pkg::t_byte_dec              raw_dec;
    iord_pkg::t_byte_dec              byte_dec;
    logic [7:0]                       byte_val;

    // handshake
    assign out_free = !r_out_valid || i_ready;
    assign emit     = r_act_valid && out_free;
    assign is_last  = (r_lane == last_lane);
    assign o_ready  = !r_act_valid || (emit && is_last);
    assign take     = i_valid && o_ready;

    // byte lane bookkeeping, size code 3 counts as longword
    assign last_lane = r_size[1] ? 2'd3 : (r_size[0] ? 2'd1 : 2'd0);
    assign shift_sel = last_lane - r_lane;
    assign byte_val  = r_wr ? r_data[{shift_sel, 3'b000} +: 8] : 8'd0;

    // per-byte address inside the mirror
    assign byte_off  = r_addr + {{(iord_pkg::MIRROR_BITS-2){1'b0}}, r_lane};
    assign long_pdma = r_size[1] && iord_pkg::is_pdma(r_addr);

    iord_decode u_decode (
        .i_offset (byte_off),
        .i_wr     (r_wr),
        .o_dec    (raw_dec)
    );

    // longword pseudo-dma goes wholly to the data register
    always_comb begin
        byte_dec = raw_dec;
        if (long_pdma) begin
            byte_dec.dev  = iord_pkg::DEV_DISK;
            byte_dec.roff = r_wr ? iord_pkg::PDMA_WR_REG : iord_pkg::PDMA_RD_REG;
            byte_dec.pen  = (r_lane == 2'd0) ? iord_pkg::LONG_PDMA_PENALTY
                                             : iord_pkg::NO_PENALTY;
        end
    end

    // next state of the sequencer and result valid
    always_comb begin
        n_act_valid = r_act_valid;
        n_lane      = r_lane;
        priority if (take) begin
            n_act_valid = 1'b1;
            n_lane      = 2'd0;
        end else if (emit && is_last) begin
            n_act_valid = 1'b0;
        end else if (emit) begin
            n_lane      = r_lane + 2'd1;
        end else begin
            n_lane      = r_lane;
        end
        n_out_valid = emit ? 1'b1 : (i_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_valid <= 1'b0;
            r_lane      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_act_valid <= n_act_valid;
            r_lane      <= n_lane;
            r_out_valid <= n_out_valid;
        end
    end

    // payload capture
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_wr   <= i_opcode;
            r_size <= i_access_size;
            r_addr <= i_bus_address[iord_pkg::MIRROR_BITS-1:0];
            r_data <= i_write_data;
        end
        if (emit) begin
            r_dec      <= byte_dec;
            r_out_wr   <= r_wr;
            r_out_byte <= byte_val;
            r_out_lane <= r_lane;
            r_out_last <= is_last;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_device_select   = r_dec.dev;
    assign o_register_offset = r_dec.roff;
    assign o_is_write        = r_out_wr;
    assign o_byte_value      = r_out_byte;
    assign o_byte_lane       = r_out_lane;
    assign o_penalty_cycles  = r_dec.pen;
    assign o_last_access     = r_out_last;

endmodule

// File: src/iord_decode.sv
module iord_decode (
    input  logic [iord_pkg::MIRROR_BITS-1:0] i_offset,
    input  logic                             i_wr,
    output iord_pkg::t_byte_dec              o_dec
);

    logic [iord_pkg::REGION_SEL_BITS-1:0] rgn;
    logic [iord_pkg::REGION_BITS-1:0]     low;
    logic [iord_pkg::REGION_BITS-1:0]     pdma_reg;

    assign rgn      = i_offset[iord_pkg::MIRROR_BITS-1:iord_pkg::REGION_BITS];
    assign low      = i_offset[iord_pkg::REGION_BITS-1:0];
    assign pdma_reg = i_wr ? iord_pkg::PDMA_WR_REG : iord_pkg::PDMA_RD_REG;

    // region lookup, offset is the position inside the 8 KB region (timers halfword aligned, pseudo-dma fixed)
    always_comb begin
        o_dec.dev  = iord_pkg::DEV_NONE;
        o_dec.roff = '0;
        o_dec.pen  = iord_pkg::NO_PENALTY;
        unique case (rgn)
            iord_pkg::RGN_TIMER1: begin
                o_dec.dev  = iord_pkg::DEV_TIMER1;
                o_dec.roff = {low[iord_pkg::REGION_BITS-1:1], 1'b0};
                o_dec.pen  = iord_pkg::TIMER_PENALTY;
            end
            iord_pkg::RGN_TIMER2: begin
                o_dec.dev  = iord_pkg::DEV_TIMER2;
                o_dec.roff = {low[iord_pkg::REGION_BITS-1:1], 1'b0};
                o_dec.pen  = iord_pkg::TIMER_PENALTY;
            end
            iord_pkg::RGN_SERIAL: begin
                o_dec.dev  = iord_pkg::DEV_SERIAL;
                o_dec.roff = low;
                o_dec.pen  = iord_pkg::OTHER_PENALTY;
            end
            iord_pkg::RGN_PDMA, iord_pkg::RGN_BLIND: begin
                o_dec.dev  = iord_pkg::DEV_DISK;
                o_dec.roff = pdma_reg;
                o_dec.pen  = iord_pkg::OTHER_PENALTY;
            end
            iord_pkg::RGN_DISKREG: begin
                o_dec.dev  = iord_pkg::DEV_DISK;
                o_dec.roff = low;
                o_dec.pen  = iord_pkg::OTHER_PENALTY;
            end
            iord_pkg::RGN_SOUND: begin
                o_dec.dev  = iord_pkg::DEV_SOUND;
                o_dec.roff = low;
                o_dec.pen  = iord_pkg::OTHER_PENALTY;
            end
            iord_pkg::RGN_FLOPPY: begin
                o_dec.dev  = iord_pkg::DEV_FLOPPY;
                o_dec.roff = low;
                o_dec.pen  = iord_pkg::OTHER_PENALTY;
            end
            default: begin
                o_dec.dev  = iord_pkg::DEV_NONE;
                o_dec.roff = '0;
                o_dec.pen  = iord_pkg::NO_PENALTY;
            end
        endcase
    end

endmodule

// File: src/iord_checker.sv
module iord_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_device_select,
    input logic [12:0] o_register_offset,
    input logic        o_is_write,
    input logic [7:0]  o_byte_value,
    input logic [1:0]  o_byte_lane,
    input logic [4:0]  o_penalty_cycles,
    input logic        o_last_access
);

    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_byte_lane)
            && $stable(o_byte_value) && $stable(o_register_offset))
        else $error("stalled byte beat changed");

    // remaining bytes of an access follow at once, lane by lane
    a_next_lane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_access |=>
            o_valid && (o_byte_lane == $past(o_byte_lane) + 2'd1))
        else $error("byte lane sequence broken");

    // unmapped byte carries no offset and no penalty
    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_device_select == iord_pkg::DEV_NONE) |->
            (o_register_offset == 13'd0) && (o_penalty_cycles == 5'd0))
        else $error("unmapped byte with offset or penalty");

    // reads carry a zero byte
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_write |-> (o_byte_value == 8'd0))
        else $error("read beat with nonzero byte");

endmodule

bind io_region_access_decoder iord_checker u_iord_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_device_select   (o_device_select),
    .o_register_offset (o_register_offset),
    .o_is_write        (o_is_write),
    .o_byte_value      (o_byte_value),
    .o_byte_lane       (o_byte_lane),
    .o_penalty_cycles  (o_penalty_cycles),
    .o_last_access     (o_last_access)
);

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam logic       OP_READ    = 1'b0;
    localparam logic       OP_WRITE   = 1'b1;
    // undefined size code, decoded as a longword
    localparam logic [1:0] SIZE_UNDEF = 2'd3;

    localparam int RANDOM_ACCESSES = 336;
    localparam int HOLD_AT_BEAT    = 120;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 16;
    localparam int CYCLE_LIMIT     = 200000;

    typedef struct {
        logic        op;
        logic [1:0]  size;
        logic [31:0] addr;
        logic [31:0] data;
    } t_access;

    typedef struct {
        iord_pkg::t_dev dev;
        logic [12:0]    roff;
        logic           wr;
        logic [7:0]     val;
        logic [1:0]     lane;
        logic [4:0]     pen;
        logic           last;
    } t_byte_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_opcode = OP_READ;
    logic [1:0]  i_access_size = iord_pkg::SIZE_BYTE;
    logic [31:0] i_bus_address = '0;
    logic [31:0] i_write_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_device_select;
    logic [12:0] o_register_offset;
    logic        o_is_write;
    logic [7:0]  o_byte_value;
    logic [1:0]  o_byte_lane;
    logic [4:0]  o_penalty_cycles;
    logic        o_last_access;

    t_access    access_q[$];
    t_byte_beat byte_beats_q[$];
    int         accesses_total = 0;
    int         accesses_taken = 0;
    int         fail_cnt = 0;
    int         cycle_cnt = 0;

    io_region_access_decoder u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_opcode          (i_opcode),
        .i_access_size     (i_access_size),
        .i_bus_address     (i_bus_address),
        .i_write_data      (i_write_data),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_device_select   (o_device_select),
        .o_register_offset (o_register_offset),
        .o_is_write        (o_is_write),
        .o_byte_value      (o_byte_value),
        .o_byte_lane       (o_byte_lane),
        .o_penalty_cycles  (o_penalty_cycles),
        .o_last_access     (o_last_access)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // decode one byte of the mirrored address space
    function automatic t_byte_beat decode_io_byte(input logic [16:0] off, input logic wr);
        t_byte_beat b;
        b = '{dev: iord_pkg::DEV_NONE, roff: '0, wr: wr, val: '0, lane: '0,
              pen: iord_pkg::NO_PENALTY, last: 1'b0};
        case (off[16:13])
            iord_pkg::RGN_TIMER1: begin
                b.dev  = iord_pkg::DEV_TIMER1; b.roff = {off[12:1], 1'b0};
                b.pen  = iord_pkg::TIMER_PENALTY;
            end
            iord_pkg::RGN_TIMER2: begin
                b.dev  = iord_pkg::DEV_TIMER2; b.roff = {off[12:1], 1'b0};
                b.pen  = iord_pkg::TIMER_PENALTY;
            end
            iord_pkg::RGN_SERIAL: begin
                b.dev  = iord_pkg::DEV_SERIAL; b.roff = off[12:0];
                b.pen  = iord_pkg::OTHER_PENALTY;
            end
            iord_pkg::RGN_PDMA, iord_pkg::RGN_BLIND: begin
                b.dev  = iord_pkg::DEV_DISK;
                b.roff = wr ? iord_pkg::PDMA_WR_REG : iord_pkg::PDMA_RD_REG;
                b.pen  = iord_pkg::OTHER_PENALTY;
            end
            iord_pkg::RGN_DISKREG: begin
                b.dev  = iord_pkg::DEV_DISK; b.roff = off[12:0];
                b.pen  = iord_pkg::OTHER_PENALTY;
            end
            iord_pkg::RGN_SOUND: begin
                b.dev  = iord_pkg::DEV_SOUND; b.roff = off[12:0];
                b.pen  = iord_pkg::OTHER_PENALTY;
            end
            iord_pkg::RGN_FLOPPY: begin
                b.dev  = iord_pkg::DEV_FLOPPY; b.roff = off[12:0];
                b.pen  = iord_pkg::OTHER_PENALTY;
            end
            default: ;
        endcase
        return b;
    endfunction

    // expected byte beats of one accepted access
    function automatic void predict_byte_beats(input t_access acc);
        int          nbytes;
        logic        long_pdma;
        logic [31:0] baddr;
        logic [31:0] shifted;
        t_byte_beat  b;
        nbytes = (acc.size == iord_pkg::SIZE_BYTE) ? 1 :
                 (acc.size == iord_pkg::SIZE_WORD) ? 2 : 4;
        long_pdma = (nbytes == 4) &&
                    (acc.addr[16:13] == iord_pkg::RGN_PDMA ||
                     acc.addr[16:13] == iord_pkg::RGN_BLIND);
        for (int k = 0; k < nbytes; k++) begin
            baddr = acc.addr + k;
            if (long_pdma) begin
                b.dev  = iord_pkg::DEV_DISK;
                b.roff = acc.op ? iord_pkg::PDMA_WR_REG : iord_pkg::PDMA_RD_REG;
                b.pen  = (k == 0) ? iord_pkg::LONG_PDMA_PENALTY : iord_pkg::NO_PENALTY;
                b.wr   = acc.op;
            end else begin
                b = decode_io_byte(baddr[16:0], acc.op);
            end
            shifted = acc.data >> ((nbytes - 1 - k) * 8);
            b.val  = acc.op ? shifted[7:0] : 8'h00;
            b.lane = k[1:0];
            b.last = (k == nbytes - 1);
            byte_beats_q.push_back(b);
        end
    endfunction

    // sender: bursts of random length with random gaps
    always @(posedge i_clk) begin
        t_access nxt;
        int      burst_left;
        int      gap_left;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (i_valid && o_ready) begin
                predict_byte_beats('{op: i_opcode, size: i_access_size,
                                     addr: i_bus_address, data: i_write_data});
                accesses_taken++;
            end
            if (i_valid && !o_ready) begin
                // hold the beat until it is taken
            end else if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (access_q.size() > 0) begin
                nxt = access_q.pop_front();
                i_opcode      <= nxt.op;
                i_access_size <= nxt.size;
                i_bus_address <= nxt.addr;
                i_write_data  <= nxt.data;
                i_valid       <= 1'b1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver: checks each byte beat and stalls on its own pattern
    always @(posedge i_clk) begin
        t_byte_beat exp_b;
        int         beats_seen;
        int         hold_left;
        bit         hold_done;
        logic [7:0] stall_cycle;
        logic       rdy;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            beats_seen = 0;
            hold_left = 0;
            hold_done = 1'b0;
            stall_cycle = '0;
        end else begin
            if (o_valid && i_ready) begin
                beats_seen++;
                if (byte_beats_q.size() == 0) begin
                    $error("byte beat with none expected: device_select %0d offset %0h",
                           o_device_select, o_register_offset);
                    fail_cnt++;
                end else begin
                    exp_b = byte_beats_q.pop_front();
                    if (o_device_select !== exp_b.dev) begin
                        $error("device_select: expected %0d, actual %0d",
                               exp_b.dev, o_device_select);
                        fail_cnt++;
                    end
                    if (o_register_offset !== exp_b.roff) begin
                        $error("register_offset: expected %0h, actual %0h",
                               exp_b.roff, o_register_offset);
                        fail_cnt++;
                    end
                    if (o_is_write !== exp_b.wr) begin
                        $error("is_write: expected %0d, actual %0d", exp_b.wr, o_is_write);
                        fail_cnt++;
                    end
                    if (o_byte_value !== exp_b.val) begin
                        $error("byte_value: expected %0h, actual %0h", exp_b.val, o_byte_value);
                        fail_cnt++;
                    end
                    if (o_byte_lane !== exp_b.lane) begin
                        $error("byte_lane: expected %0d, actual %0d", exp_b.lane, o_byte_lane);
                        fail_cnt++;
                    end
                    if (o_penalty_cycles !== exp_b.pen) begin
                        $error("penalty_cycles: expected %0d, actual %0d",
                               exp_b.pen, o_penalty_cycles);
                        fail_cnt++;
                    end
                    if (o_last_access !== exp_b.last) begin
                        $error("last_access: expected %0d, actual %0d",
                               exp_b.last, o_last_access);
                        fail_cnt++;
                    end
                end
            end
            // one long hold-off so the decoder backs up into its input
            if (!hold_done && beats_seen >= HOLD_AT_BEAT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            stall_cycle++;
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                case (stall_cycle[7:6])
                    2'd0: rdy = 1'b1;
                    2'd1: rdy = ($urandom_range(0, 3) != 0);
                    2'd2: rdy = ($urandom_range(0, 3) == 0);
                    default: rdy = stall_cycle[0];
                endcase
            end
            i_ready <= rdy;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        t_access acc;
        // region edges, boundary crossings, pseudo-dma longwords, address wrap
        access_q.push_back('{OP_READ,  iord_pkg::SIZE_BYTE, 32'h0000_0000, 32'h0000_0000});
        access_q.push_back('{OP_WRITE, iord_pkg::SIZE_BYTE, 32'h0000_0001, 32'h0000_00A5});
        access_q.push_back('{OP_WRITE, iord_pkg::SIZE_WORD, 32'h0000_1FFF, 32'h0000_BEEF});
        access_q.push_back('{OP_READ,  iord_pkg::SIZE_WORD, 32'h0000_3FFF, 32'hFFFF_FFFF});
        access_q.push_back('{OP_WRITE, iord_pkg::SIZE_LONG, 32'h0000_5FFE, 32'h1234_5678});
        access_q.push_back('{OP_READ,  iord_pkg::SIZE_LONG, 32'h0000_6000, 32'h0000_0000});
        access_q.push_back('{OP_WRITE, iord_pkg::SIZE_LONG, 32'h0000_7FFF, 32'hDEAD_BEEF});
        access_q.push_back('{OP_WRITE, iord_pkg::SIZE_BYTE, 32'h0000_6123, 32'h0000_003C});
        access_q.push_back('{OP_READ,  iord_pkg::SIZE_WORD, 32'h0000_7FFF, 32'h0000_0000});
        access_q.push_back('{OP_WRITE, iord_pkg::SIZE_LONG, 32'h0000_FFFE, 32'hCAFE_F00D});
        access_q.push_back('{OP_READ,  iord_pkg::SIZE_LONG, 32'h0001_1FFE, 32'h0000_0000});
        access_q.push_back('{OP_WRITE, SIZE_UNDEF,          32'h0001_2000, 32'hFFFF_FFFF});
        access_q.push_back('{OP_READ,  SIZE_UNDEF,          32'h0001_3FFF, 32'h0000_0000});
        access_q.push_back('{OP_WRITE, iord_pkg::SIZE_WORD, 32'h0001_5FFF, 32'h0000_00FF});
        access_q.push_back('{OP_WRITE, iord_pkg::SIZE_LONG, 32'h0001_7FFE, 32'h8000_0001});
        access_q.push_back('{OP_READ,  iord_pkg::SIZE_LONG, 32'h0001_FFFE, 32'h0000_0000});
        access_q.push_back('{OP_WRITE, iord_pkg::SIZE_LONG, 32'hFFFF_FFFF, 32'h0102_0304});
        access_q.push_back('{OP_READ,  iord_pkg::SIZE_BYTE, 32'hFFFE_5ABC, 32'h0000_0000});
        access_q.push_back('{OP_WRITE, SIZE_UNDEF,          32'h0000_4010, 32'hA5A5_5A5A});
        access_q.push_back('{OP_WRITE, iord_pkg::SIZE_BYTE, 32'h0000_A000, 32'h0000_007F});
        access_q.push_back('{OP_READ,  iord_pkg::SIZE_LONG, 32'h0000_C000, 32'h0000_0000});
        access_q.push_back('{OP_WRITE, iord_pkg::SIZE_WORD, 32'h0001_E000, 32'hFFFF_1234});
        access_q.push_back('{OP_WRITE, iord_pkg::SIZE_BYTE, 32'h0001_4000, 32'hFFFF_FF00});
        access_q.push_back('{OP_WRITE, iord_pkg::SIZE_LONG, 32'h0001_6000, 32'hFFFF_FFFF});
        access_q.push_back('{OP_READ,  iord_pkg::SIZE_WORD, 32'h8001_0001, 32'h0000_0000});

        // random accesses aimed at every region and its edges
        for (int n = 0; n < RANDOM_ACCESSES; n++) begin
            acc.op   = 1'($urandom_range(0, 1));
            acc.size = ($urandom_range(0, 9) == 0) ? SIZE_UNDEF : 2'($urandom_range(0, 2));
            acc.data = $urandom();
            acc.addr = $urandom();
            acc.addr[16:13] = 4'($urandom_range(0, 15));
            case ($urandom_range(0, 3))
                0: acc.addr[12:0] = 13'($urandom_range(0, 3));
                1: acc.addr[12:0] = 13'h1FFF - 13'($urandom_range(0, 3));
                default: ;
            endcase
            access_q.push_back(acc);
        end
        accesses_total = access_q.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accesses_taken < accesses_total) @(posedge i_clk);
        while (byte_beats_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
